@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files of the gesture classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hdl/bcg_pkg.sv @@
// Package with the codes and constants of the button click gesture classifier.
package bcg_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Gesture codes carried on the output tuser.
    typedef enum logic [1:0] {
        GEST_CLICK  = 2'd0,
        GEST_DOUBLE = 2'd1,
        GEST_LONG   = 2'd2
    } t_gesture;

    // Configuration registers.
    localparam int CFG_W = 32;
    localparam logic [0:0] CFG_HOLD_LIMIT   = 1'b0;
    localparam logic [0:0] CFG_DOUBLE_LIMIT = 1'b1;
    localparam logic [CFG_W-1:0] HOLD_LIMIT_RST   = 32'd500000;
    localparam logic [CFG_W-1:0] DOUBLE_LIMIT_RST = 32'd300000;

endpackage

@@ hdl/button_click_gesture_classifier_core.sv @@
// Top level of the button click, double click and long press classifier.
//
// Items arrive as ticks, key presses or key releases and may be accepted in
// every cycle. An accepted item lands in an input register; when the output
// register is free or being taken, it is classified against the held and
// pending key state, the state is updated, and any gesture is written to the
// output register. The sustained rate is one item per clock while the output
// does not stall; the timer add and limit compare lie between the input and
// result registers. When the output register is full and not taken, the
// input register holds and the input stalls.
`include "assert_macros.svh"
module button_click_gesture_classifier_core
    import bcg_pkg::*;
#(
    parameter int KEY_BITS  = 5,
    parameter int TIME_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input stream.
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata fields from bit 0 up: key_code, elapsed, zero padding.
    input  logic [((KEY_BITS+TIME_BITS+7)/8)*8-1:0] i_s_tdata,
    // tuser fields: kind.
    input  logic [1:0]                            i_s_tuser,
    // Output stream.
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tdata fields from bit 0 up: gesture_key, zero padding.
    output logic [((KEY_BITS+7)/8)*8-1:0]         o_m_tdata,
    // tuser fields: gesture.
    output logic [1:0]                            o_m_tuser,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [0:0]                            i_cfg_idx,
    input  logic [CFG_W-1:0]                      i_cfg_data
);
    localparam int OUT_W = ((KEY_BITS + 7) / 8) * 8;

    // Configuration.
    logic [CFG_W-1:0] r_hold_limit;
    logic [CFG_W-1:0] r_double_limit;

    // Input stage.
    logic                 r_in_valid;
    logic [1:0]           r_in_kind;
    logic [KEY_BITS-1:0]  r_in_key;
    logic [TIME_BITS-1:0] r_in_elapsed;

    // Classifier state.
    logic [KEY_BITS-1:0]  r_held_key,     n_held_key;
    logic [TIME_BITS-1:0] r_hold_timer,   n_hold_timer;
    logic [KEY_BITS-1:0]  r_pending_key,  n_pending_key;
    logic                 r_window_open,  n_window_open;
    logic [TIME_BITS-1:0] r_window_timer, n_window_timer;

    // Output stage.
    logic                r_out_valid;
    t_gesture            r_out_gesture;
    logic [KEY_BITS-1:0] r_out_key;

    logic                 s1_adv;
    logic                 res_valid;
    t_gesture             res_gesture;
    logic [KEY_BITS-1:0]  res_key;
    logic [TIME_BITS-1:0] hold_sum;
    logic                 hold_over;
    logic [TIME_BITS-1:0] win_sum;
    logic                 win_over;
    logic                 long_fired;

    assign s1_adv     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || s1_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_key);
    assign o_m_tuser  = r_out_gesture;

    bcg_sat_timer #(.TIME_BITS(TIME_BITS)) u_hold_timer (
        .i_timer   (r_hold_timer),
        .i_elapsed (r_in_elapsed),
        .i_limit   (r_hold_limit),
        .o_sum     (hold_sum),
        .o_over    (hold_over)
    );

    bcg_sat_timer #(.TIME_BITS(TIME_BITS)) u_window_timer (
        .i_timer   (r_window_timer),
        .i_elapsed (r_in_elapsed),
        .i_limit   (r_double_limit),
        .o_sum     (win_sum),
        .o_over    (win_over)
    );

    always_comb begin
        n_held_key     = r_held_key;
        n_hold_timer   = r_hold_timer;
        n_pending_key  = r_pending_key;
        n_window_open  = r_window_open;
        n_window_timer = r_window_timer;
        res_valid      = 1'b0;
        res_gesture    = GEST_CLICK;
        res_key        = r_pending_key;
        long_fired     = 1'b0;
        case (r_in_kind)
            KIND_TICK: begin
                if (r_held_key != '0) begin
                    n_hold_timer = hold_sum;
                    if (hold_over) begin
                        long_fired     = 1'b1;
                        res_valid      = 1'b1;
                        res_gesture    = GEST_LONG;
                        res_key        = r_held_key;
                        n_held_key     = '0;
                        n_hold_timer   = '0;
                        n_pending_key  = '0;
                        n_window_open  = 1'b0;
                        n_window_timer = '0;
                    end
                end
                // A long press drops the pending click, so the window is not advanced.
                if (!long_fired && r_window_open && r_pending_key != '0) begin
                    n_window_timer = win_sum;
                    if (win_over) begin
                        res_valid      = 1'b1;
                        res_gesture    = GEST_CLICK;
                        res_key        = r_pending_key;
                        n_pending_key  = '0;
                        n_window_open  = 1'b0;
                        n_window_timer = '0;
                    end
                end
            end
            KIND_PRESS: begin
                if (r_in_key != '0) begin
                    if (r_pending_key == '0) begin
                        n_pending_key = r_in_key;
                    end else if (r_pending_key != r_in_key) begin
                        res_valid     = 1'b1;
                        res_gesture   = GEST_CLICK;
                        res_key       = r_pending_key;
                        n_pending_key = r_in_key;
                        n_window_open = 1'b0;
                    end else if (r_window_open) begin
                        res_valid     = 1'b1;
                        res_gesture   = GEST_DOUBLE;
                        res_key       = r_pending_key;
                        n_pending_key = '0;
                        n_window_open = 1'b0;
                    end
                    n_window_timer = '0;
                    n_held_key     = r_in_key;
                    n_hold_timer   = '0;
                end
            end
            KIND_RELEASE: begin
                if (r_in_key != '0) begin
                    if (r_in_key == r_held_key) begin
                        n_held_key   = '0;
                        n_hold_timer = '0;
                    end
                    if (r_in_key == r_pending_key) begin
                        if (r_window_open) begin
                            res_valid      = 1'b1;
                            res_gesture    = GEST_CLICK;
                            res_key        = r_in_key;
                            n_pending_key  = '0;
                            n_window_open  = 1'b0;
                            n_window_timer = '0;
                        end else begin
                            n_window_open  = 1'b1;
                            n_window_timer = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_limit   <= HOLD_LIMIT_RST;
            r_double_limit <= DOUBLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD_LIMIT:   r_hold_limit   <= i_cfg_data;
                CFG_DOUBLE_LIMIT: r_double_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_held_key     <= '0;
            r_hold_timer   <= '0;
            r_pending_key  <= '0;
            r_window_open  <= 1'b0;
            r_window_timer <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (s1_adv) begin
                r_out_valid    <= res_valid;
                r_held_key     <= n_held_key;
                r_hold_timer   <= n_hold_timer;
                r_pending_key  <= n_pending_key;
                r_window_open  <= n_window_open;
                r_window_timer <= n_window_timer;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind    <= i_s_tuser;
            r_in_key     <= i_s_tdata[KEY_BITS-1:0];
            r_in_elapsed <= i_s_tdata[KEY_BITS +: TIME_BITS];
        end
        if (s1_adv && res_valid) begin
            r_out_gesture <= res_gesture;
            r_out_key     <= res_key;
        end
    end

    // A key that is not held never carries hold time.
    `ASSERT_CLK(a_hold_idle, i_clk, i_rst_n, (r_held_key == '0) |-> (r_hold_timer == '0), "hold timer runs without a held key")
    // An open window always belongs to a pending key.
    `ASSERT_CLK(a_window_key, i_clk, i_rst_n, r_window_open |-> (r_pending_key != '0), "window open without a pending key")
    // The window timer only counts while the window is open.
    `ASSERT_CLK(a_window_idle, i_clk, i_rst_n, !r_window_open |-> (r_window_timer == '0), "window timer runs while closed")
    // An item in the input stage is never lost while the output stalls.
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, (r_in_valid && !s1_adv) |=> r_in_valid, "input stage item dropped during stall")

endmodule

@@ hdl/bcg_sat_timer.sv @@
// Saturating timer advance with a compare against its limit.
module bcg_sat_timer
    import bcg_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] i_timer,
    input  logic [TIME_BITS-1:0] i_elapsed,
    input  logic [CFG_W-1:0]     i_limit,
    output logic [TIME_BITS-1:0] o_sum,
    output logic                 o_over
);
    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    logic [TIME_BITS:0] full;

    assign full   = {1'b0, i_timer} + {1'b0, i_elapsed};
    assign o_sum  = full[TIME_BITS] ? {TIME_BITS{1'b1}} : full[TIME_BITS-1:0];
    assign o_over = CMP_W'(o_sum) > CMP_W'(i_limit);

endmodule
